// ===== sv/gtp_pkg.sv =====
// Shared types, codes and constants of the grid turtle plotter.
`timescale 1ns / 1ps
`default_nettype none

package gtp_pkg;

    localparam int MAX_SIDE_DEF = 32;

    localparam int KIND_W   = 3;
    localparam int DIST_W   = 6;
    localparam int GRID_W   = 6;
    localparam int QRY_W    = 5;
    localparam int OCOORD_W = 5;
    localparam int HEAD_W   = 2;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(32);

    localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HOME  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd5;

    localparam logic [HEAD_W-1:0] HD_EAST  = 2'd0;
    localparam logic [HEAD_W-1:0] HD_WEST  = 2'd1;
    localparam logic [HEAD_W-1:0] HD_SOUTH = 2'd2;
    localparam logic [HEAD_W-1:0] HD_NORTH = 2'd3;

    typedef struct packed {
        logic accept;
        logic step;
        logic capture;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic go_move;
        logic go_read;
        logic last_step;
    } t_dp_stat;

    function automatic logic [HEAD_W-1:0] turn_right(input logic [HEAD_W-1:0] h);
        logic [HEAD_W-1:0] r;
        unique case (h)
            HD_EAST:  r = HD_SOUTH;
            HD_SOUTH: r = HD_WEST;
            HD_WEST:  r = HD_NORTH;
            HD_NORTH: r = HD_EAST;
            default:  r = HD_EAST;
        endcase
        return r;
    endfunction

    function automatic logic [HEAD_W-1:0] turn_left(input logic [HEAD_W-1:0] h);
        logic [HEAD_W-1:0] r;
        unique case (h)
            HD_EAST:  r = HD_NORTH;
            HD_NORTH: r = HD_WEST;
            HD_WEST:  r = HD_SOUTH;
            HD_SOUTH: r = HD_EAST;
            default:  r = HD_EAST;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gtp_bitmap.sv =====
// Row-wide bitmap memory with per-row valid flags, so a clear only resets the flags.
`timescale 1ns / 1ps
`default_nettype none

module gtp_bitmap #(
    parameter int MAX_SIDE = gtp_pkg::MAX_SIDE_DEF,
    localparam int CW = $clog2(MAX_SIDE)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_clr,
    input  wire logic                i_we,
    input  wire logic [CW-1:0]       i_wr_row,
    input  wire logic [CW-1:0]       i_wr_col,
    input  wire logic                i_re,
    input  wire logic [CW-1:0]       i_rd_row,
    output logic      [MAX_SIDE-1:0] o_rd_bits
);

    logic [MAX_SIDE-1:0] r_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] r_valid;
    logic [MAX_SIDE-1:0] r_rd_data;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_wr_row] <= 1'b1;
        end
    end

    // A row not yet valid is written whole, so stale bits never show.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < MAX_SIDE; b++) begin
                if (!r_valid[i_wr_row] || (i_wr_col == CW'(b))) begin
                    r_mem[i_wr_row][b] <= (i_wr_col == CW'(b));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data  <= r_mem[i_rd_row];
            r_rd_valid <= r_valid[i_rd_row];
        end
    end

    assign o_rd_bits = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== sv/gtp_dp.sv =====
// Datapath: turtle position, heading, grid size, move walker and result register.
`timescale 1ns / 1ps
`default_nettype none

module gtp_dp #(
    parameter int MAX_SIDE = gtp_pkg::MAX_SIDE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gtp_pkg::t_dp_cmd              i_cmd,
    output gtp_pkg::t_dp_stat                  o_stat,
    input  wire logic                          i_cfg_we,
    input  wire logic [gtp_pkg::GRID_W-1:0]    i_cfg_data,
    input  wire logic [gtp_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [gtp_pkg::DIST_W-1:0]    i_distance,
    input  wire logic                          i_pen_down,
    input  wire logic [gtp_pkg::QRY_W-1:0]     i_query_col,
    input  wire logic [gtp_pkg::QRY_W-1:0]     i_query_row,
    output logic                               o_accepted,
    output logic      [gtp_pkg::OCOORD_W-1:0]  o_col,
    output logic      [gtp_pkg::OCOORD_W-1:0]  o_row,
    output logic      [gtp_pkg::HEAD_W-1:0]    o_heading_now,
    output logic                               o_cell_value
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int AW = ((CW > gtp_pkg::DIST_W) ? CW : gtp_pkg::DIST_W) + 1;

    logic [CW-1:0]                 r_col, n_col;
    logic [CW-1:0]                 r_row, n_row;
    logic [gtp_pkg::HEAD_W-1:0]    r_head, n_head;
    logic [gtp_pkg::GRID_W-1:0]    r_grid;
    logic                          r_acc, n_acc;
    logic                          r_cell, n_cell;
    logic [gtp_pkg::DIST_W-1:0]    r_cnt, n_cnt;
    logic                          r_pen, n_pen;
    logic [CW-1:0]                 r_qcol, n_qcol;
    logic                          r_qok, n_qok;

    logic                          r_o_acc;
    logic [gtp_pkg::OCOORD_W-1:0]  r_o_col;
    logic [gtp_pkg::OCOORD_W-1:0]  r_o_row;
    logic [gtp_pkg::HEAD_W-1:0]    r_o_head;
    logic                          r_o_cell;

    logic [AW-1:0]       side;
    logic [AW-1:0]       grid_ext;
    logic [AW-1:0]       col_ext;
    logic [AW-1:0]       row_ext;
    logic [AW-1:0]       dist_ext;
    logic [AW-1:0]       qc_ext;
    logic [AW-1:0]       qr_ext;
    logic [AW-1:0]       col_out;
    logic [AW-1:0]       row_out;
    logic                move_ok;
    logic                q_ok;
    logic                clr;
    logic                rd_en;
    logic [MAX_SIDE-1:0] rd_bits;

    assign grid_ext = AW'(r_grid);
    assign col_ext  = AW'(r_col);
    assign row_ext  = AW'(r_row);
    assign dist_ext = AW'(i_distance);
    assign qc_ext   = AW'(i_query_col);
    assign qr_ext   = AW'(i_query_row);
    assign col_out  = AW'(r_col);
    assign row_out  = AW'(r_row);

    always_comb begin
        priority if (grid_ext == '0) begin
            side = AW'(1);
        end else if (grid_ext > AW'(MAX_SIDE)) begin
            side = AW'(MAX_SIDE);
        end else begin
            side = grid_ext;
        end
    end

    always_comb begin
        unique case (r_head)
            gtp_pkg::HD_EAST:  move_ok = (col_ext + dist_ext) < side;
            gtp_pkg::HD_WEST:  move_ok = dist_ext <= col_ext;
            gtp_pkg::HD_SOUTH: move_ok = (row_ext + dist_ext) < side;
            gtp_pkg::HD_NORTH: move_ok = dist_ext <= row_ext;
            default:           move_ok = 1'b0;
        endcase
    end

    assign q_ok = (qc_ext < side) && (qr_ext < side);

    assign o_stat.go_move   = (i_kind == gtp_pkg::KIND_MOVE) && move_ok && (i_distance != '0);
    assign o_stat.go_read   = (i_kind == gtp_pkg::KIND_READ);
    assign o_stat.last_step = (r_cnt == gtp_pkg::DIST_W'(1));

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_head = r_head;
        n_acc  = r_acc;
        n_cell = r_cell;
        n_cnt  = r_cnt;
        n_pen  = r_pen;
        n_qcol = r_qcol;
        n_qok  = r_qok;
        clr    = 1'b0;
        rd_en  = 1'b0;
        if (i_cmd.accept) begin
            n_acc  = 1'b1;
            n_cell = 1'b0;
            n_cnt  = i_distance;
            n_pen  = i_pen_down;
            n_qcol = qc_ext[CW-1:0];
            n_qok  = q_ok;
            unique case (i_kind)
                gtp_pkg::KIND_RIGHT: n_head = gtp_pkg::turn_right(r_head);
                gtp_pkg::KIND_LEFT:  n_head = gtp_pkg::turn_left(r_head);
                gtp_pkg::KIND_MOVE:  n_acc  = move_ok;
                gtp_pkg::KIND_HOME: begin
                    n_col = '0;
                    n_row = '0;
                end
                gtp_pkg::KIND_CLEAR: clr   = 1'b1;
                gtp_pkg::KIND_READ:  rd_en = 1'b1;
                default:             n_acc = 1'b0;
            endcase
        end
        if (i_cmd.step) begin
            n_cnt = r_cnt - gtp_pkg::DIST_W'(1);
            unique case (r_head)
                gtp_pkg::HD_EAST:  n_col = r_col + CW'(1);
                gtp_pkg::HD_WEST:  n_col = r_col - CW'(1);
                gtp_pkg::HD_SOUTH: n_row = r_row + CW'(1);
                gtp_pkg::HD_NORTH: n_row = r_row - CW'(1);
                default:           n_col = r_col;
            endcase
        end
        if (i_cmd.capture) begin
            n_cell = r_qok && rd_bits[r_qcol];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_head <= gtp_pkg::HD_EAST;
            r_grid <= gtp_pkg::GRID_RESET;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_head <= n_head;
            if (i_cfg_we) begin
                r_grid <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_cell <= n_cell;
        r_cnt  <= n_cnt;
        r_pen  <= n_pen;
        r_qcol <= n_qcol;
        r_qok  <= n_qok;
        if (i_cmd.load) begin
            r_o_acc  <= r_acc;
            r_o_col  <= col_out[gtp_pkg::OCOORD_W-1:0];
            r_o_row  <= row_out[gtp_pkg::OCOORD_W-1:0];
            r_o_head <= r_head;
            r_o_cell <= r_cell;
        end
    end

    gtp_bitmap #(
        .MAX_SIDE (MAX_SIDE)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (clr),
        .i_we      (i_cmd.step && r_pen),
        .i_wr_row  (r_row),
        .i_wr_col  (r_col),
        .i_re      (rd_en),
        .i_rd_row  (qr_ext[CW-1:0]),
        .o_rd_bits (rd_bits)
    );

    assign o_accepted    = r_o_acc;
    assign o_col         = r_o_col;
    assign o_row         = r_o_row;
    assign o_heading_now = r_o_head;
    assign o_cell_value  = r_o_cell;

endmodule

`default_nettype wire

// ===== sv/gtp_ctrl.sv =====
// Controller: command sequencing and result handshake.
`timescale 1ns / 1ps
`default_nettype none

module gtp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output gtp_pkg::t_dp_cmd        o_cmd,
    input  wire gtp_pkg::t_dp_stat  i_stat
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOVE = 4'b0010,
        S_READ = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   load;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;
    assign load       = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_stat.go_move) begin
                        n_state = S_MOVE;
                    end else if (i_stat.go_read) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_MOVE: begin
                if (i_stat.last_step) begin
                    n_state = S_FIN;
                end
            end
            S_READ: n_state = S_FIN;
            S_FIN: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.accept  = accept;
    assign o_cmd.step    = (r_state == S_MOVE);
    assign o_cmd.capture = (r_state == S_READ);
    assign o_cmd.load    = load;
    assign o_out_valid   = r_out_valid;

endmodule

`default_nettype wire

// ===== sv/grid_turtle_plotter.sv =====
// Top level of the grid turtle plotter: stream ports, controller and datapath.
//
// Commands arrive on the s_axis channel, one item each; the command kind rides
// in s_axis_tuser and its operands in s_axis_tdata. Every command yields exactly
// one result item on m_axis: accept flag, turtle position, heading and the cell
// bit for a read. The grid side is written through the cfg channel, which is
// always ready; write it only while no command is in flight.
// Turn, home, clear, a refused move, a zero-length move and an unknown kind go
// straight to the finish state; a read passes a read state for the registered
// row read of the bitmap; a move runs the walker, which steps one cell per cycle
// and marks it with the pen down. One command is in flight at a time.
// A finished result sits in an output register, so the next item is taken while
// the receiver stalls; a following result waits until that register frees.
// Reset (synchronous, active low) homes the turtle facing east, sets the grid
// side to 32 and clears the bitmap at once through per-row valid flags; no
// clearing pass follows, and the clear command clears the same way.
`timescale 1ns / 1ps
`default_nettype none

module grid_turtle_plotter #(
    parameter int MAX_SIDE = gtp_pkg::MAX_SIDE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // distance[5:0], pen_down[6], query_col[11:7], query_row[16:12], zero fill
    input  wire logic [gtp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind[2:0]
    input  wire logic [gtp_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // accepted[0], col[5:1], row[10:6], heading_now[12:11], cell_value[13], zero fill
    output logic      [gtp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [gtp_pkg::GRID_W-1:0]      i_cfg_data
);

    gtp_pkg::t_dp_cmd                  cmd;
    gtp_pkg::t_dp_stat                 stat;
    logic                              accepted;
    logic [gtp_pkg::OCOORD_W-1:0]      col;
    logic [gtp_pkg::OCOORD_W-1:0]      row;
    logic [gtp_pkg::HEAD_W-1:0]        heading_now;
    logic                              cell_value;

    assign o_cfg_ready = 1'b1;

    gtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    gtp_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (s_axis_tuser[2:0]),
        .i_distance    (s_axis_tdata[5:0]),
        .i_pen_down    (s_axis_tdata[6]),
        .i_query_col   (s_axis_tdata[11:7]),
        .i_query_row   (s_axis_tdata[16:12]),
        .o_accepted    (accepted),
        .o_col         (col),
        .o_row         (row),
        .o_heading_now (heading_now),
        .o_cell_value  (cell_value)
    );

    assign m_axis_tdata = {2'b00, cell_value, heading_now, row, col, accepted};

`ifndef SYNTHESIS
    a_no_input_while_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !s_axis_tready)
        else $error("input taken while a move is walking");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over one not yet taken");

    a_cell_implies_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[13]) |-> m_axis_tdata[0])
        else $error("cell bit set on a refused command");

    a_accept_leads_to_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("controller idle right after taking an item");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the grid turtle plotter: command streams checked against a turtle model.
`timescale 1ns / 1ps

module testbench;
    import gtp_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 8;
    localparam int SIDE_MAX = 32;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 40;
    localparam int SHOW_LIMIT = 10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DIST_W-1:0] span;
        logic              pen;
        logic [QRY_W-1:0]  qcol;
        logic [QRY_W-1:0]  qrow;
    } plot_cmd_t;

    typedef struct packed {
        logic                accepted;
        logic [OCOORD_W-1:0] col;
        logic [OCOORD_W-1:0] row;
        logic [HEAD_W-1:0]   heading;
        logic                cell_bit;
    } plot_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [S_TDATA_W-1:0] s_data = '0;
    logic [S_TUSER_W-1:0] s_user = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [M_TDATA_W-1:0] m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [GRID_W-1:0] cfg_data = '0;

    logic [SIDE_MAX*SIDE_MAX-1:0] canvas = '0;
    logic [OCOORD_W-1:0] turtle_col = '0;
    logic [OCOORD_W-1:0] turtle_row = '0;
    logic [HEAD_W-1:0] facing = HD_EAST;
    logic [GRID_W-1:0] grid_reg = GRID_RESET;

    plot_report_t pending_reports[$];
    int errors = 0;
    int idle_cycles = 0;
    int rx_hold = 0;
    bit quiet = 1'b0;

    grid_turtle_plotter u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int side_in_effect();
        if (grid_reg == 0) return 1;
        if (grid_reg > SIDE_MAX) return SIDE_MAX;
        return int'(grid_reg);
    endfunction

    function automatic int move_reach();
        int n;
        n = side_in_effect();
        case (facing)
            HD_EAST:  return n - 1 - int'(turtle_col);
            HD_SOUTH: return n - 1 - int'(turtle_row);
            HD_WEST:  return int'(turtle_col);
            default:  return int'(turtle_row);
        endcase
    endfunction

    function automatic void predict_command(input plot_cmd_t c);
        plot_report_t rep;
        int n;
        rep = '0;
        rep.accepted = 1'b1;
        case (c.kind)
            KIND_RIGHT: begin
                case (facing)
                    HD_EAST:  facing = HD_SOUTH;
                    HD_SOUTH: facing = HD_WEST;
                    HD_WEST:  facing = HD_NORTH;
                    default:  facing = HD_EAST;
                endcase
            end
            KIND_LEFT: begin
                case (facing)
                    HD_EAST:  facing = HD_NORTH;
                    HD_NORTH: facing = HD_WEST;
                    HD_WEST:  facing = HD_SOUTH;
                    default:  facing = HD_EAST;
                endcase
            end
            KIND_MOVE: begin
                if (int'(c.span) > move_reach()) begin
                    rep.accepted = 1'b0;
                end else begin
                    for (int i = 0; i < int'(c.span); i++) begin
                        if (c.pen) canvas[int'(turtle_row) * SIDE_MAX + int'(turtle_col)] = 1'b1;
                        case (facing)
                            HD_EAST:  turtle_col = turtle_col + 1'b1;
                            HD_WEST:  turtle_col = turtle_col - 1'b1;
                            HD_SOUTH: turtle_row = turtle_row + 1'b1;
                            default:  turtle_row = turtle_row - 1'b1;
                        endcase
                    end
                end
            end
            KIND_HOME: begin
                turtle_col = '0;
                turtle_row = '0;
            end
            KIND_CLEAR: canvas = '0;
            KIND_READ: begin
                n = side_in_effect();
                if (int'(c.qcol) < n && int'(c.qrow) < n)
                    rep.cell_bit = canvas[int'(c.qrow) * SIDE_MAX + int'(c.qcol)];
            end
            default: rep.accepted = 1'b0;
        endcase
        rep.col = turtle_col;
        rep.row = turtle_row;
        rep.heading = facing;
        pending_reports.push_back(rep);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_command(input logic [KIND_W-1:0] kind, input int span = 0,
                                input bit pen = 1'b0, input int qcol = 0, input int qrow = 0);
        plot_cmd_t c;
        int gap;
        c.kind = kind;
        c.span = DIST_W'(span);
        c.pen = pen;
        c.qcol = QRY_W'(qcol);
        c.qrow = QRY_W'(qrow);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_user <= c.kind;
        s_data <= {7'd0, c.qrow, c.qcol, c.pen, c.span};
        do @(posedge clk); while (!s_ready);
        predict_command(c);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
    endtask

    task automatic write_grid(input logic [GRID_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        grid_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_turns();
        send_command(KIND_RIGHT);
        send_command(KIND_LEFT);
        send_command(KIND_LEFT);
        send_command(KIND_RIGHT);
    endtask

    task automatic test_draw_and_read();
        send_command(KIND_MOVE, 5, 1'b1);
        send_command(KIND_READ, 0, 1'b0, 0, 0);
        send_command(KIND_READ, 0, 1'b0, 4, 0);
        send_command(KIND_READ, 0, 1'b0, 5, 0);
        send_command(KIND_MOVE, 0, 1'b1);
        send_command(KIND_MOVE, 63, 1'b1);
        send_command(KIND_RIGHT);
        send_command(KIND_MOVE, 3, 1'b1);
        send_command(KIND_READ, 0, 1'b0, 5, 2);
        send_command(KIND_HOME);
    endtask

    task automatic test_clear_and_unknown();
        send_command(KIND_MOVE, 31, 1'b0);
        send_command(KIND_CLEAR);
        send_command(KIND_READ, 0, 1'b0, 0, 0);
        send_command(KIND_READ + 3'd1, 63, 1'b1, 31, 31);
        send_command(KIND_READ + 3'd2, 0, 1'b0, 0, 0);
    endtask

    task automatic test_shrunken_grid();
        write_grid(4);
        send_command(KIND_MOVE, 0, 1'b1);
        send_command(KIND_RIGHT);
        send_command(KIND_MOVE, 0, 1'b1);
        send_command(KIND_READ, 0, 1'b0, 31, 0);
        send_command(KIND_HOME);
        write_grid(0);
        send_command(KIND_RIGHT);
        send_command(KIND_MOVE, 1, 1'b1);
    endtask

    task automatic test_random_mix(input logic [GRID_W-1:0] size, input int count,
                                   input bit calm);
        logic [KIND_W-1:0] kind;
        int roll;
        int reach;
        int n;
        int span;
        bit pen;
        int qc;
        int qr;
        write_grid(size);
        quiet = calm;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            reach = move_reach();
            n = side_in_effect();
            span = $urandom_range(0, 63);
            pen = $urandom_range(0, 1);
            qc = $urandom_range(0, 31);
            qr = $urandom_range(0, 31);
            if (roll < 45) begin
                kind = KIND_MOVE;
                if (reach >= 0 && $urandom_range(0, 3) != 0) span = $urandom_range(0, reach);
                pen = ($urandom_range(0, 4) != 0);
            end else if (roll < 60) begin
                kind = KIND_RIGHT;
            end else if (roll < 70) begin
                kind = KIND_LEFT;
            end else if (roll < 88) begin
                kind = KIND_READ;
                if ($urandom_range(0, 4) != 0) begin
                    qc = $urandom_range(0, n - 1);
                    qr = $urandom_range(0, n - 1);
                end
            end else if (roll < 93) begin
                kind = KIND_HOME;
            end else if (roll < 96) begin
                kind = KIND_CLEAR;
            end else begin
                kind = KIND_W'($urandom_range(6, 7));
            end
            if (k == count / 2 || $urandom_range(0, 49) == 0) drain_results();
            send_command(kind, span, pen, qc, qr);
        end
        quiet = 1'b0;
    endtask

    always @(negedge clk) begin
        int roll;
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_hold = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(7, 39);
            end
        end
    end

    always @(posedge clk) begin
        plot_report_t want;
        plot_report_t got;
        if (rst_n && m_valid && m_ready) begin
            got = {m_data[0], m_data[5:1], m_data[10:6], m_data[12:11], m_data[13]};
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("tb: unexpected item acc=%0d col=%0d row=%0d head=%0d cell=%0d",
                             got.accepted, got.col, got.row, got.heading, got.cell_bit);
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display({"tb: mismatch expected acc=%0d col=%0d row=%0d head=%0d ",
                                  "cell=%0d, got acc=%0d col=%0d row=%0d head=%0d cell=%0d"},
                                 want.accepted, want.col, want.row, want.heading, want.cell_bit,
                                 got.accepted, got.col, got.row, got.heading, got.cell_bit);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_turns();
        test_draw_and_read();
        test_clear_and_unknown();
        test_shrunken_grid();
        test_random_mix(6, 60, 1'b0);
        test_random_mix(32, 70, 1'b0);
        test_random_mix(63, 40, 1'b0);
        test_random_mix(3, 60, 1'b0);
        test_random_mix(1, 20, 1'b0);
        test_random_mix(0, 20, 1'b0);
        test_random_mix(10, 70, 1'b1);
        test_random_mix(33, 40, 1'b0);
        test_random_mix(2, 70, 1'b0);
        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && pending_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
sv/gtp_pkg.sv
sv/gtp_bitmap.sv
sv/gtp_dp.sv
sv/gtp_ctrl.sv
sv/grid_turtle_plotter.sv
tb/sv/testbench.sv
